// File: rtl/dma_pkg.sv
// Shared widths, register indexes and types of the decimating moving average.
package dma_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned GROUP_W      = 11;
  localparam int unsigned WINLEN_W     = 6;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam int unsigned WINDOW_DEPTH = 32;
  localparam int unsigned MAX_GROUP    = 1024;

  localparam int unsigned SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int unsigned COUNT_W      = $clog2(MAX_GROUP);
  localparam int unsigned TOTAL_W      = 21;
  localparam int unsigned DIV_STEPS    = TOTAL_W;
  localparam int unsigned STEP_W       = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_START,
    ST_DIVIDE
  } dma_state_e;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [GROUP_W-1:0]  group_len;
    logic [WINLEN_W-1:0] window_len;
  } dma_cfg_t;

  // Strobes from the sequencer to the window datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic clear;
  } dma_win_ctrl_t;

endpackage

// File: rtl/decimating_moving_average.sv
// Top level of the decimating moving average: registers, sequencer, output word.
//
// Each accepted sample is added to a group sum; when group_size samples are in,
// the low 16 bits of the sum go into the next slot of a ring of window_length
// entries and the group restarts. Every sample yields one output word: a flag
// telling whether it closed a group, and the ring's mean truncated toward zero.
// A sample passes through these steps in order: it is accepted and added to the
// group sum, the ring and its running total are updated, the divider is loaded,
// the serial divider produces one quotient bit per cycle, and the output
// register is loaded. The next sample is taken as soon as the output register
// is loaded, even if that word has not been read yet; while an unread word
// still sits in the output register, the finished quotient waits.
// Writing either configuration register clears the group sum, the ring and the
// running total at once; there is no clearing pass after reset.
module decimating_moving_average
  import dma_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        group_done_o,
  output logic signed [SAMPLE_W-1:0]  window_average_o
);

  dma_state_e state_q, state_d;

  logic [GROUP_W-1:0]  group_size_q, group_size_d;
  logic [WINLEN_W-1:0] window_length_q, window_length_d;
  logic                cfg_hit;

  logic                       out_valid_q, out_valid_d;
  logic                       out_done_q;
  logic signed [SAMPLE_W-1:0] out_avg_q;

  dma_cfg_t                   cfg;
  dma_win_ctrl_t              win_ctrl;
  logic                       win_done;
  logic signed [TOTAL_W-1:0]  win_total;
  logic                       div_start;
  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] div_quot;

  logic in_fire;
  logic out_load;

  // Register writes.
  always_comb begin
    group_size_d    = group_size_q;
    window_length_d = window_length_q;
    cfg_hit         = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GROUP_SIZE: begin
          group_size_d = cfg_data_i[GROUP_W-1:0];
          cfg_hit      = 1'b1;
        end
        REG_WINDOW_LENGTH: begin
          window_length_d = cfg_data_i[WINLEN_W-1:0];
          cfg_hit         = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q    <= GROUP_W'(1);
      window_length_q <= WINLEN_W'(WINDOW_DEPTH);
    end else begin
      group_size_q    <= group_size_d;
      window_length_q <= window_length_d;
    end
  end

  // Zero acts as one and oversized values saturate.
  always_comb begin
    if (group_size_q == '0) begin
      cfg.group_len = GROUP_W'(1);
    end else if (group_size_q > GROUP_W'(MAX_GROUP)) begin
      cfg.group_len = GROUP_W'(MAX_GROUP);
    end else begin
      cfg.group_len = group_size_q;
    end
    if (window_length_q == '0) begin
      cfg.window_len = WINLEN_W'(1);
    end else if (window_length_q > WINLEN_W'(WINDOW_DEPTH)) begin
      cfg.window_len = WINLEN_W'(WINDOW_DEPTH);
    end else begin
      cfg.window_len = window_length_q;
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Sequencer.
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    win_ctrl.accept = 1'b0;
    win_ctrl.commit = 1'b0;
    win_ctrl.clear  = cfg_hit;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        win_ctrl.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        win_ctrl.commit = 1'b1;
        state_d         = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // Hold the finished quotient until the output register is free.
        if (!div_busy && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_done_q <= win_done;
      out_avg_q  <= div_quot;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign group_done_o     = out_done_q;
  assign window_average_o = out_avg_q;

  dma_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (win_ctrl),
    .cfg_i          (cfg),
    .sample_i       (sample_i),
    .group_done_o   (win_done),
    .window_total_o (win_total)
  );

  dma_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (win_total),
    .divisor_i  (cfg.window_len),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

`ifndef SYNTHESIS
  a_ready_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("input ready while the divider is still running");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start after a load");

  a_fire_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second sample taken before the first was processed");

  a_load_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && (group_done_o == $past(win_done))))
    else $error("output word not loaded with the group flag");
`endif

endmodule

// File: rtl/dma_window.sv
// Group accumulator, ring of group entries and running window total.
module dma_window
  import dma_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dma_win_ctrl_t              ctrl_i,
  input  dma_cfg_t                   cfg_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       group_done_o,
  output logic signed [TOTAL_W-1:0]  window_total_o
);

  logic signed [SAMPLE_W-1:0] group_sum_q, group_sum_d;
  logic [COUNT_W-1:0]         group_count_q, group_count_d;
  logic                       done_q, done_d;
  logic signed [SAMPLE_W-1:0] entry_q, entry_d;
  logic signed [TOTAL_W-1:0]  total_q, total_d;
  logic [SLOT_W-1:0]          next_slot_q, next_slot_d;
  logic [WINDOW_DEPTH-1:0]    valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] store_q [WINDOW_DEPTH];

  logic signed [SAMPLE_W-1:0] sum_next;
  logic [GROUP_W-1:0]         count_inc;
  logic                       group_full;
  logic signed [SAMPLE_W-1:0] old_entry;
  logic [WINLEN_W-1:0]        slot_inc;
  logic                       do_write;

  always_comb begin
    sum_next   = group_sum_q + sample_i;
    count_inc  = GROUP_W'(group_count_q) + GROUP_W'(1);
    group_full = (count_inc >= cfg_i.group_len);
    // A slot never written since the last clear reads as zero.
    old_entry  = valid_q[next_slot_q] ? store_q[next_slot_q] : '0;
    slot_inc   = WINLEN_W'(next_slot_q) + WINLEN_W'(1);
    do_write   = ctrl_i.commit && done_q;

    group_sum_d   = group_sum_q;
    group_count_d = group_count_q;
    done_d        = done_q;
    entry_d       = entry_q;
    total_d       = total_q;
    next_slot_d   = next_slot_q;
    valid_d       = valid_q;

    if (ctrl_i.clear) begin
      group_sum_d   = '0;
      group_count_d = '0;
      done_d        = 1'b0;
      total_d       = '0;
      next_slot_d   = '0;
      valid_d       = '0;
    end else if (ctrl_i.accept) begin
      entry_d = sum_next;
      done_d  = group_full;
      if (group_full) begin
        group_sum_d   = '0;
        group_count_d = '0;
      end else begin
        group_sum_d   = sum_next;
        group_count_d = count_inc[COUNT_W-1:0];
      end
    end else if (do_write) begin
      total_d = total_q
              - {{(TOTAL_W-SAMPLE_W){old_entry[SAMPLE_W-1]}}, old_entry}
              + {{(TOTAL_W-SAMPLE_W){entry_q[SAMPLE_W-1]}}, entry_q};
      next_slot_d = (slot_inc == cfg_i.window_len) ? '0 : slot_inc[SLOT_W-1:0];
      valid_d[next_slot_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_sum_q   <= '0;
      group_count_q <= '0;
      done_q        <= 1'b0;
      total_q       <= '0;
      next_slot_q   <= '0;
      valid_q       <= '0;
    end else begin
      group_sum_q   <= group_sum_d;
      group_count_q <= group_count_d;
      done_q        <= done_d;
      total_q       <= total_d;
      next_slot_q   <= next_slot_d;
      valid_q       <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.clear && do_write) begin
      store_q[next_slot_q] <= entry_q;
    end
  end

  assign group_done_o   = done_q;
  assign window_total_o = total_q;

endmodule

// File: rtl/dma_divider.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module dma_divider
  import dma_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [TOTAL_W-1:0]  dividend_i,
  input  logic [WINLEN_W-1:0]        divisor_i,
  output logic                       busy_o,
  output logic signed [SAMPLE_W-1:0] quotient_o
);

  logic                busy_q, busy_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                neg_q, neg_d;
  logic [TOTAL_W-1:0]  dvd_q, dvd_d;
  logic [WINLEN_W-1:0] rem_q, rem_d;
  logic [WINLEN_W-1:0] div_q, div_d;

  logic [WINLEN_W:0]   trial;
  logic                fits;
  logic [WINLEN_W:0]   diff;
  logic [SAMPLE_W-1:0] mag;

  always_comb begin
    trial = {rem_q, dvd_q[TOTAL_W-1]};
    fits  = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};

    busy_d = busy_q;
    step_d = step_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;

    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_STEPS - 1);
      neg_d  = dividend_i[TOTAL_W-1];
      // The most negative total still has an exact unsigned magnitude here.
      dvd_d  = dividend_i[TOTAL_W-1] ? (~dividend_i + TOTAL_W'(1)) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TOTAL_W-2:0], fits};
      rem_d = fits ? diff[WINLEN_W-1:0] : trial[WINLEN_W-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign mag        = dvd_q[SAMPLE_W-1:0];
  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? (~mag + SAMPLE_W'(1)) : mag;

endmodule

// File: test/tb_decimating_moving_average.sv
// Self-checking testbench of the decimating moving average.
`timescale 1ns / 100ps

module tb_decimating_moving_average;
  import dma_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct {
    logic                       done;
    logic signed [SAMPLE_W-1:0] average;
  } avg_word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       group_done_o;
  logic signed [SAMPLE_W-1:0] window_average_o;

  decimating_moving_average dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .group_done_o     (group_done_o),
    .window_average_o (window_average_o)
  );

  // Our own copy of the configuration and the averaging state.
  logic [GROUP_W-1:0]         group_size_reg;
  logic [WINLEN_W-1:0]        window_length_reg;
  int                         grp_sum;
  int                         grp_count;
  logic signed [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  int                         ring_slot;
  int                         ring_total;

  avg_word_t expected_averages[$];
  int        error_count     = 0;
  int        samples_sent    = 0;
  int        averages_seen   = 0;
  int        register_writes = 0;

  // Receiver shaping.
  bit          ready_throttle = 1'b0;
  int          hold_left      = 0;
  logic [15:0] ready_pattern  = 16'hA5F3;
  int          pattern_pos    = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int window_span();
    if (window_length_reg == 0) return 1;
    if (window_length_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return int'(window_length_reg);
  endfunction

  function automatic void clear_averaging();
    grp_sum    = 0;
    grp_count  = 0;
    ring_total = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) ring[i] = '0;
    ring_slot  = window_span() - 1;
  endfunction

  // Works out the word that one accepted sample must produce.
  function automatic void predict_average(input logic signed [SAMPLE_W-1:0] value);
    avg_word_t                  word;
    int                         span;
    int                         target;
    int                         quotient;
    logic signed [SAMPLE_W-1:0] entry;
    span = window_span();
    if (group_size_reg == 0) target = 1;
    else if (group_size_reg > MAX_GROUP) target = MAX_GROUP;
    else target = int'(group_size_reg);
    grp_sum   += value;
    grp_count += 1;
    word.done = 1'b0;
    if (grp_count >= target) begin
      // The ring entry keeps only the low half of the group sum.
      entry      = grp_sum[SAMPLE_W-1:0];
      ring_slot  = (ring_slot + 1) % span;
      ring_total = ring_total - ring[ring_slot] + entry;
      ring[ring_slot] = entry;
      grp_sum    = 0;
      grp_count  = 0;
      word.done  = 1'b1;
    end
    quotient     = ring_total / span;
    word.average = quotient[SAMPLE_W-1:0];
    expected_averages.push_back(word);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    avg_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      averages_seen++;
      if (expected_averages.size() == 0) begin
        report_mismatch($sformatf("unexpected word done=%0b average=%0d",
                                  group_done_o, window_average_o));
      end else begin
        want = expected_averages.pop_front();
        if (group_done_o !== want.done)
          report_mismatch($sformatf("group_done %0b, expected %0b", group_done_o, want.done));
        if (window_average_o !== want.average)
          report_mismatch($sformatf("window_average %0d, expected %0d",
                                    window_average_o, want.average));
      end
    end
  end

  // Receiver: a long hold when asked, else always ready or a rotating random pattern.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!ready_throttle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ready_pattern[pattern_pos];
      pattern_pos = (pattern_pos + 1) % 16;
      if (pattern_pos == 0) ready_pattern = 16'($urandom) | 16'h0101;
    end
  end

  task automatic wait_for_drain();
    while (expected_averages.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    register_writes++;
    if (idx == REG_GROUP_SIZE) begin
      group_size_reg = value[GROUP_W-1:0];
      clear_averaging();
    end else if (idx == REG_WINDOW_LENGTH) begin
      window_length_reg = value[WINLEN_W-1:0];
      clear_averaging();
    end
  endtask

  // Offers one word; valid stays high afterwards only when another word follows at once.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input bit keep_valid);
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_average(value);
    samples_sent++;
    if (!keep_valid) in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit extremes_only);
    case ($urandom_range(0, extremes_only ? 1 : 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic feed_samples(input int count, input bit gaps, input bit extremes_only);
    int burst;
    bit pause;
    bit last;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      last  = (i == count - 1);
      burst = burst - 1;
      pause = gaps && (burst == 0);
      send_sample(pick_sample(extremes_only), !(last || pause));
      if (pause && !last) begin
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  // Default registers: one sample per group, all 32 slots averaged.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b0);
  endtask

  // Zero and oversized register values take their clamped meaning.
  task automatic test_register_clamps();
    write_register(REG_GROUP_SIZE, '0);
    write_register(REG_WINDOW_LENGTH, '0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(63));
    send_sample(16'sh8000, 1'b1);
    send_sample(-16'sd31, 1'b0);
  endtask

  // Group sums wrap to 16 bits before they enter the ring.
  task automatic test_group_wrap();
    write_register(REG_GROUP_SIZE, CFG_DATA_W'(2));
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(1));
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
  endtask

  // Writes to unused indexes change nothing and leave a half-built group alone.
  task automatic test_unknown_index();
    send_sample(16'sd1234, 1'b0);
    write_register(REG_SPARE_2, CFG_DATA_W'(5));
    write_register(REG_SPARE_3, '1);
    send_sample(-16'sd4321, 1'b0);
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] group_val;
    logic [WINLEN_W-1:0]   win_val;
    logic [CFG_DATA_W-1:0] win_data;
    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 5))
        0:       group_val = CFG_DATA_W'(1);
        1:       group_val = CFG_DATA_W'(2);
        2:       group_val = CFG_DATA_W'(3);
        3:       group_val = CFG_DATA_W'($urandom_range(4, 12));
        4:       group_val = CFG_DATA_W'($urandom_range(13, 40));
        default: group_val = '0;
      endcase
      case ($urandom_range(0, 4))
        0:       win_val = WINLEN_W'(1);
        1:       win_val = WINLEN_W'(32);
        2:       win_val = WINLEN_W'($urandom_range(33, 63));
        3:       win_val = '0;
        default: win_val = WINLEN_W'($urandom_range(2, 31));
      endcase
      // The bits above the window field must be ignored.
      win_data = {5'($urandom), win_val};
      if ($urandom_range(0, 1) == 0) begin
        write_register(REG_GROUP_SIZE, group_val);
        write_register(REG_WINDOW_LENGTH, win_data);
      end else begin
        write_register(REG_WINDOW_LENGTH, win_data);
        write_register(REG_GROUP_SIZE, group_val);
      end
      ready_throttle = (phase != 4);
      feed_samples($urandom_range(6, 12), phase != 2, 1'b0);
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    write_register(REG_GROUP_SIZE, CFG_DATA_W'(1));
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(4));
    ready_throttle = 1'b1;
    hold_left = 300;
    feed_samples(20, 1'b0, 1'b0);
    wait_for_drain();
    write_register(REG_GROUP_SIZE, CFG_DATA_W'(3));
    feed_samples(24, 1'b1, 1'b0);
  endtask

  // An oversized group register acts as the largest group; loud samples stress the sum.
  task automatic test_largest_group();
    write_register(REG_GROUP_SIZE, '1);
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
    ready_throttle = 1'b0;
    feed_samples(MAX_GROUP + 1, 1'b0, 1'b1);
  endtask

  initial begin
    group_size_reg    = GROUP_W'(1);
    window_length_reg = WINLEN_W'(32);
    clear_averaging();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_clamps();
    test_group_wrap();
    test_unknown_index();
    test_random_settings();
    test_output_backpressure();
    test_largest_group();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_averages.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_averages.size()));
    $display("Sent %0d samples and checked %0d averages over %0d register writes,",
             samples_sent, averages_seen, register_writes);
    $display("with clamped settings, 16-bit group wrap, output stalls and the largest group.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d words outstanding.", expected_averages.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
